>>> rtl/core/rcps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcps_pkg: shared definitions of the RC pulse capture and servo sequencer
// Channel count, counter widths, register indexes, item kinds and the
// reset table of the commanded pulse widths.
// ----------------------------------------------------------------------------
package rcps_pkg;

    localparam int CHANNELS     = 4;
    localparam int COUNTER_BITS = 16;
    localparam int PINS         = (CHANNELS < 4) ? CHANNELS : 4;
    localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PHASE_W      = $clog2(2 * CHANNELS);
    localparam int CMD_W        = 11;
    localparam int CFG_W        = 16;
    localparam int DIV_W        = 7;
    localparam int DCNT_W       = 6;
    localparam int IDX_W        = 3;
    localparam int PORT_W       = 2;
    localparam int LEVEL_W      = 4;
    localparam int BYTE_W       = 8;

    localparam logic [DIV_W-1:0] DIV_MIN = DIV_W'(1);
    localparam logic [DIV_W-1:0] DIV_MAX = DIV_W'(64);

    localparam logic [COUNTER_BITS-1:0] COMPARE_RESET = COUNTER_BITS'(10);
    localparam logic [PHASE_W-1:0]      PHASE_RESET   = PHASE_W'(2 * CHANNELS - 1);

    localparam logic [CMD_W-1:0] CMD_RESET [8] = '{
        CMD_W'(1000), CMD_W'(1326), CMD_W'(1568), CMD_W'(1812),
        CMD_W'(1000), CMD_W'(1000), CMD_W'(1000), CMD_W'(1000)
    };

    localparam logic [CFG_W-1:0] MIN_WIDTH_RESET    = CFG_W'(125);
    localparam logic [CFG_W-1:0] MAX_WIDTH_RESET    = CFG_W'(250);
    localparam logic [CFG_W-1:0] SLOT_LENGTH_RESET  = CFG_W'(2000);
    localparam logic [CFG_W-1:0] FRAME_LENGTH_RESET = CFG_W'(20000);
    localparam logic [DIV_W-1:0] DIVIDER_RESET      = DIV_W'(8);

    typedef enum logic [IDX_W-1:0] {
        REG_MIN_WIDTH       = 3'd0,
        REG_MAX_WIDTH       = 3'd1,
        REG_SLOT_LENGTH     = 3'd2,
        REG_FRAME_LENGTH    = 3'd3,
        REG_CAPTURE_DIVIDER = 3'd4
    } cfg_index_t;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_MSG  = 1'b1;

    function automatic logic [LEVEL_W-1:0] gen_levels(input logic [PHASE_W-1:0] phase);
        logic [LEVEL_W-1:0] levels;
        levels = '0;
        for (int i = 0; i < PINS; i++)
        begin
            levels[i] = !phase[0] && (phase[PHASE_W-1:1] == (PHASE_W-1)'(i));
        end
        return levels;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/rc_pulse_capture_and_servo_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc_pulse_capture_and_servo_sequencer: four-channel RC pulse block
// Samples radio pins on tick items, measures pulse widths, sequences servo
// pulses in auto mode and mirrors the radio pins in manual mode. Message
// items write commanded widths or read back one byte.
//
//   Channel  Handshake            Payload
//   in       in_valid/in_ready    func, radio_levels, msg_first, msg_second
//   out      out_valid/out_ready  ctrl_levels, manual_mode, reply_valid,
//                                 reply_data
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An accepted item is held in the input register until its result is written
// into the result register, from which the out channel presents it.
// Between stalls one item is accepted per clock, set by the single update stage.
// The input register stalls only while a result waits and out_ready is low.
// Reset restores the configuration and state registers; cfg_ready is always high.
// ----------------------------------------------------------------------------
module rc_pulse_capture_and_servo_sequencer
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           func,
    input  wire logic [rcps_pkg::LEVEL_W-1:0]   radio_levels,
    input  wire logic [rcps_pkg::BYTE_W-1:0]    msg_first,
    input  wire logic [rcps_pkg::BYTE_W-1:0]    msg_second,

    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [rcps_pkg::LEVEL_W-1:0]        ctrl_levels,
    output logic                                manual_mode,
    output logic                                reply_valid,
    output logic [rcps_pkg::BYTE_W-1:0]         reply_data,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rcps_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [rcps_pkg::CFG_W-1:0]     cfg_data
);
    import rcps_pkg::*;

    logic                    in_valid_reg;
    logic                    func_reg;
    logic [LEVEL_W-1:0]      radio_reg;
    logic [BYTE_W-1:0]       msg_first_reg;
    logic [BYTE_W-1:0]       msg_second_reg;

    logic                    out_valid_reg;
    logic [LEVEL_W-1:0]      ctrl_levels_reg;
    logic                    manual_mode_reg;
    logic                    reply_valid_reg;
    logic [BYTE_W-1:0]       reply_data_reg;

    logic [CFG_W-1:0]        min_width_reg;
    logic [CFG_W-1:0]        max_width_reg;
    logic [CFG_W-1:0]        slot_length_reg;
    logic [CFG_W-1:0]        frame_length_reg;
    logic [DIV_W-1:0]        divider_reg;

    logic                    manual_reg, manual_next;
    logic [LEVEL_W-1:0]      prev_levels_reg, prev_levels_next;
    logic [COUNTER_BITS-1:0] capture_count_reg, capture_count_next;
    logic [DCNT_W-1:0]       divider_count_reg, divider_count_next;
    logic [COUNTER_BITS-1:0] edge_start_reg [CHANNELS];
    logic [COUNTER_BITS-1:0] edge_start_next [CHANNELS];
    logic [CFG_W-1:0]        measured_reg [CHANNELS];
    logic [CFG_W-1:0]        measured_next [CHANNELS];
    logic [CMD_W-1:0]        cmd_width_reg [CHANNELS];
    logic [CMD_W-1:0]        cmd_width_next [CHANNELS];
    logic [PHASE_W-1:0]      phase_reg, phase_next;
    logic [COUNTER_BITS-1:0] gen_count_reg, gen_count_next;
    logic [COUNTER_BITS-1:0] compare_reg, compare_next;
    logic [COUNTER_BITS-1:0] gap_reg, gap_next;

    logic                    advance;
    logic                    valid_next;
    logic [BYTE_W-1:0]       data_next;
    logic [LEVEL_W-1:0]      levels_next;

    logic [LEVEL_W-1:0]      rise;
    logic [LEVEL_W-1:0]      fall;
    logic [COUNTER_BITS-1:0] delta;
    logic [DIV_W-1:0]        div_eff;
    logic [DIV_W-1:0]        div_count_inc;
    logic [CH_W-1:0]         cur_ch;
    logic [CH_W-1:0]         next_ch;
    logic [COUNTER_BITS-1:0] next_width;
    logic [COUNTER_BITS-1:0] slots_before_last;
    logic [PORT_W-1:0]       port;
    logic                    port_ok;
    logic [CFG_W-1:0]        scaled_cmd;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign out_valid   = out_valid_reg;
    assign ctrl_levels = ctrl_levels_reg;
    assign manual_mode = manual_mode_reg;
    assign reply_valid = reply_valid_reg;
    assign reply_data  = reply_data_reg;

    assign slots_before_last = COUNTER_BITS'(32'(slot_length_reg) * (CHANNELS - 1));
    assign port    = msg_first_reg[5:4];
    assign port_ok = (32'(port) < CHANNELS);

    always_comb
    begin
        manual_next        = manual_reg;
        prev_levels_next   = prev_levels_reg;
        capture_count_next = capture_count_reg;
        divider_count_next = divider_count_reg;
        edge_start_next    = edge_start_reg;
        measured_next      = measured_reg;
        cmd_width_next     = cmd_width_reg;
        phase_next         = phase_reg;
        gen_count_next     = gen_count_reg;
        compare_next       = compare_reg;
        gap_next           = gap_reg;
        valid_next         = 1'b0;
        data_next          = '0;
        rise               = radio_reg & ~prev_levels_reg;
        fall               = prev_levels_reg & ~radio_reg;
        delta              = '0;
        cur_ch             = CH_W'(phase_reg[PHASE_W-1:1]);
        next_ch            = (cur_ch == CH_W'(CHANNELS - 1)) ? '0 : cur_ch + CH_W'(1);
        next_width         = COUNTER_BITS'(cmd_width_reg[next_ch]);
        scaled_cmd         = CFG_W'(cmd_width_reg[CH_W'(port)]) - {min_width_reg[CFG_W-3:0], 2'b00};

        if (divider_reg < DIV_MIN)
        begin
            div_eff = DIV_MIN;
        end
        else if (divider_reg > DIV_MAX)
        begin
            div_eff = DIV_MAX;
        end
        else
        begin
            div_eff = divider_reg;
        end
        div_count_inc = DIV_W'(divider_count_reg) + DIV_W'(1);

        if (func_reg == FUNC_TICK)
        begin
            for (int i = 0; i < PINS; i++)
            begin
                delta = capture_count_reg - edge_start_reg[i];
                if (delta > max_width_reg)
                begin
                    delta = max_width_reg;
                end
                if (delta < min_width_reg)
                begin
                    delta = min_width_reg;
                end
                if (rise[i])
                begin
                    edge_start_next[i] = capture_count_reg;
                end
                else if (fall[i])
                begin
                    measured_next[i] = delta - min_width_reg;
                end
            end
            if (rise[3])
            begin
                manual_next = 1'b1;
            end
            prev_levels_next = radio_reg;

            if (div_count_inc >= div_eff)
            begin
                divider_count_next = '0;
                capture_count_next = capture_count_reg + COUNTER_BITS'(1);
            end
            else
            begin
                divider_count_next = div_count_inc[DCNT_W-1:0];
            end

            if (!manual_next)
            begin
                if (gen_count_reg != compare_reg)
                begin
                    gen_count_next = gen_count_reg + COUNTER_BITS'(1);
                end
                else
                begin
                    gen_count_next = '0;
                    if (phase_reg[0])
                    begin
                        phase_next   = {PHASE_W'(next_ch)} << 1;
                        compare_next = next_width;
                        if (next_ch == CH_W'(CHANNELS - 1))
                        begin
                            gap_next = frame_length_reg - slots_before_last - next_width;
                        end
                        else
                        begin
                            gap_next = slot_length_reg - next_width;
                        end
                    end
                    else
                    begin
                        phase_next   = phase_reg + PHASE_W'(1);
                        compare_next = gap_reg;
                    end
                end
            end
        end
        else
        begin
            if (msg_first_reg[7])
            begin
                if ((^(msg_first_reg ^ msg_second_reg)) && port_ok)
                begin
                    cmd_width_next[CH_W'(port)] = {msg_first_reg[3:0], msg_second_reg[7:1]};
                end
            end
            else if (^msg_first_reg)
            begin
                valid_next = 1'b1;
                if (port_ok)
                begin
                    if (msg_first_reg[6])
                    begin
                        data_next = measured_reg[CH_W'(port)][BYTE_W-1:0];
                    end
                    else
                    begin
                        data_next = scaled_cmd[BYTE_W+1:2];
                    end
                end
            end
        end

        levels_next = manual_next ? prev_levels_next : gen_levels(phase_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            func_reg       <= func;
            radio_reg      <= radio_levels;
            msg_first_reg  <= msg_first;
            msg_second_reg <= msg_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ctrl_levels_reg <= levels_next;
            manual_mode_reg <= manual_next;
            reply_valid_reg <= valid_next;
            reply_data_reg  <= data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_width_reg    <= MIN_WIDTH_RESET;
            max_width_reg    <= MAX_WIDTH_RESET;
            slot_length_reg  <= SLOT_LENGTH_RESET;
            frame_length_reg <= FRAME_LENGTH_RESET;
            divider_reg      <= DIVIDER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                REG_MIN_WIDTH:       min_width_reg    <= cfg_data;
                REG_MAX_WIDTH:       max_width_reg    <= cfg_data;
                REG_SLOT_LENGTH:     slot_length_reg  <= cfg_data;
                REG_FRAME_LENGTH:    frame_length_reg <= cfg_data;
                REG_CAPTURE_DIVIDER: divider_reg      <= cfg_data[DIV_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            manual_reg        <= 1'b0;
            prev_levels_reg   <= '0;
            capture_count_reg <= '0;
            divider_count_reg <= '0;
            phase_reg         <= PHASE_RESET;
            gen_count_reg     <= '0;
            compare_reg       <= COMPARE_RESET;
            gap_reg           <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                edge_start_reg[i] <= '0;
                measured_reg[i]   <= '0;
                cmd_width_reg[i]  <= CMD_RESET[i % 8];
            end
        end
        else if (advance)
        begin
            manual_reg        <= manual_next;
            prev_levels_reg   <= prev_levels_next;
            capture_count_reg <= capture_count_next;
            divider_count_reg <= divider_count_next;
            phase_reg         <= phase_next;
            gen_count_reg     <= gen_count_next;
            compare_reg       <= compare_next;
            gap_reg           <= gap_next;
            edge_start_reg    <= edge_start_next;
            measured_reg      <= measured_next;
            cmd_width_reg     <= cmd_width_next;
        end
    end

`ifndef SYNTHESIS
    a_manual_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        manual_reg |=> manual_reg)
        else $error("manual mode was left");

    a_generator_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        manual_reg |=> $stable(gen_count_reg) && $stable(phase_reg))
        else $error("generator moved in manual mode");

    a_message_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && func_reg == FUNC_MSG) |=> $stable(capture_count_reg)
            && $stable(divider_count_reg) && $stable(prev_levels_reg))
        else $error("message item advanced the capture state");

    a_auto_one_pin: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !manual_mode_reg) |-> $onehot0(ctrl_levels_reg))
        else $error("more than one generated pulse is high");

    a_reply_on_message: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && func_reg == FUNC_TICK) |=> !reply_valid_reg)
        else $error("tick item produced a reply");
`endif

endmodule
`default_nettype wire

>>> dv/rc_pulse_capture_and_servo_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pulse_capture_and_servo_sequencer_tb: self-checking bench of the RC block
// Drives tick and message items with random gaps and output stalls. It
// reprograms the clamps, the slot and frame lengths and the capture divider
// between phases, and checks every reply against a cycle-free model of the
// sequencer, the capture logic and the message port.
// ----------------------------------------------------------------------------
import rcps_pkg::*;

localparam logic [BYTE_W-1:0] MSG_WRITE = 8'h80;
localparam logic [BYTE_W-1:0] MSG_RADIO = 8'h40;
localparam int                THROTTLE  = 3;

typedef struct packed {
    logic [LEVEL_W-1:0] levels;
    logic               manual;
    logic               has_data;
    logic [BYTE_W-1:0]  data;
} pin_reply_t;

class servo_capture_tracker;
    logic [CFG_W-1:0]        min_w, max_w, slot_len, frame_len;
    logic [DIV_W-1:0]        cap_div;
    logic                    manual;
    logic [LEVEL_W-1:0]      prev_lv;
    logic [COUNTER_BITS-1:0] cap_cnt;
    logic [DCNT_W-1:0]       div_cnt;
    logic [COUNTER_BITS-1:0] rise_at [CHANNELS];
    logic [COUNTER_BITS-1:0] width_meas [CHANNELS];
    logic [CMD_W-1:0]        width_cmd [CHANNELS];
    logic [PHASE_W-1:0]      phase;
    logic [COUNTER_BITS-1:0] gen_cnt, compare, gap;
    pin_reply_t              pending [$];
    int                      errors;

    function new();
        min_w     = MIN_WIDTH_RESET;
        max_w     = MAX_WIDTH_RESET;
        slot_len  = SLOT_LENGTH_RESET;
        frame_len = FRAME_LENGTH_RESET;
        cap_div   = DIVIDER_RESET;
        manual    = 1'b0;
        prev_lv   = '0;
        cap_cnt   = '0;
        div_cnt   = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            rise_at[i]    = '0;
            width_meas[i] = '0;
            width_cmd[i]  = CMD_RESET[i];
        end
        phase   = PHASE_RESET;
        gen_cnt = '0;
        compare = COMPARE_RESET;
        gap     = '0;
        errors  = 0;
    endfunction

    function void set_register(cfg_index_t idx, logic [CFG_W-1:0] value);
        case (idx)
            REG_MIN_WIDTH:       min_w = value;
            REG_MAX_WIDTH:       max_w = value;
            REG_SLOT_LENGTH:     slot_len = value;
            REG_FRAME_LENGTH:    frame_len = value;
            REG_CAPTURE_DIVIDER: cap_div = value[DIV_W-1:0];
            default: ;
        endcase
    endfunction

    function void apply_item(logic kind, logic [LEVEL_W-1:0] lv,
                             logic [BYTE_W-1:0] b1, logic [BYTE_W-1:0] b2);
        pin_reply_t              want;
        logic [LEVEL_W-1:0]      rise, fall;
        logic [COUNTER_BITS-1:0] span;
        logic [15:0]             scaled;
        logic [PORT_W-1:0]       port;
        int                      step, nxt;
        want = '0;
        if (kind == FUNC_TICK)
        begin
            rise = lv & ~prev_lv;
            fall = prev_lv & ~lv;
            for (int i = 0; i < PINS; i++)
            begin
                if (rise[i])
                    rise_at[i] = cap_cnt;
                else if (fall[i])
                begin
                    span = cap_cnt - rise_at[i];
                    if (span > max_w)
                        span = max_w;
                    if (span < min_w)
                        span = min_w;
                    width_meas[i] = span - min_w;
                end
            end
            if (rise[THROTTLE])
                manual = 1'b1;
            prev_lv = lv;

            step = (cap_div == 0) ? 1 : ((cap_div > 64) ? 64 : int'(cap_div));
            if (int'(div_cnt) + 1 >= step)
            begin
                div_cnt = '0;
                cap_cnt = cap_cnt + 1'b1;
            end
            else
                div_cnt = div_cnt + 1'b1;

            if (!manual)
            begin
                if (gen_cnt != compare)
                    gen_cnt = gen_cnt + 1'b1;
                else
                begin
                    gen_cnt = '0;
                    if (phase[0])
                    begin
                        nxt     = (int'(phase >> 1) + 1) % CHANNELS;
                        phase   = PHASE_W'(2 * nxt);
                        compare = COUNTER_BITS'(width_cmd[nxt]);
                        if (nxt == CHANNELS - 1)
                            gap = COUNTER_BITS'(int'(frame_len) - (CHANNELS - 1) * int'(slot_len)
                                                - int'(width_cmd[nxt]));
                        else
                            gap = COUNTER_BITS'(int'(slot_len) - int'(width_cmd[nxt]));
                    end
                    else
                    begin
                        phase   = phase + 1'b1;
                        compare = gap;
                    end
                end
            end
        end
        else
        begin
            port = b1[5:4];
            if ((b1 & MSG_WRITE) != 0)
            begin
                if (^{b1, b2})
                    width_cmd[port] = {b1[3:0], b2[7:1]};
            end
            else if (^b1)
            begin
                want.has_data = 1'b1;
                if ((b1 & MSG_RADIO) != 0)
                    want.data = width_meas[port][7:0];
                else
                begin
                    scaled    = 16'(int'(width_cmd[port]) - 4 * int'(min_w));
                    want.data = scaled[9:2];
                end
            end
        end
        want.manual = manual;
        if (manual)
            want.levels = prev_lv;
        else if (!phase[0])
            want.levels[phase >> 1] = 1'b1;
        pending.push_back(want);
    endfunction

    function void compare_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    function void check_reply(pin_reply_t got);
        pin_reply_t want;
        if (pending.size() == 0)
        begin
            errors++;
            $display("%0t: result with nothing expected, actual %h", $time, got);
            return;
        end
        want = pending.pop_front();
        compare_field("ctrl_levels", want.levels, got.levels);
        compare_field("manual_mode", want.manual, got.manual);
        compare_field("reply_valid", want.has_data, got.has_data);
        compare_field("reply_data", want.data, got.data);
    endfunction
endclass

module rc_pulse_capture_and_servo_sequencer_tb;

    localparam int WATCHDOG_LIMIT = 4000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                func;
    logic [LEVEL_W-1:0]  radio_levels;
    logic [BYTE_W-1:0]   msg_first;
    logic [BYTE_W-1:0]   msg_second;
    logic                out_valid;
    logic                out_ready;
    logic [LEVEL_W-1:0]  ctrl_levels;
    logic                manual_mode;
    logic                reply_valid;
    logic [BYTE_W-1:0]   reply_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    bit                  src_gaps;
    bit                  sink_stalls;
    logic [LEVEL_W-1:0]  radio_now;
    int                  quiet_cycles;

    servo_capture_tracker board = new();

    rc_pulse_capture_and_servo_sequencer dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .radio_levels (radio_levels),
        .msg_first    (msg_first),
        .msg_second   (msg_second),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .ctrl_levels  (ctrl_levels),
        .manual_mode  (manual_mode),
        .reply_valid  (reply_valid),
        .reply_data   (reply_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_reply({ctrl_levels, manual_mode, reply_valid, reply_data});
            if (cfg_valid && cfg_ready)
                board.set_register(cfg_index_t'(cfg_index), cfg_data);
            if (in_valid && in_ready)
                board.apply_item(func, radio_levels, msg_first, msg_second);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_stalls && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    function automatic logic [15:0] write_msg(input logic [PORT_W-1:0] port,
                                              input logic [CMD_W-1:0] width, input bit good);
        logic [BYTE_W-1:0] b1, b2;
        b1 = MSG_WRITE | {2'b00, port, width[10:7]};
        if ($urandom_range(0, 1) != 0)
            b1 = b1 | MSG_RADIO;
        b2    = {width[6:0], 1'b0};
        b2[0] = good ^ (^b1) ^ (^b2);
        return {b1, b2};
    endfunction

    function automatic logic [15:0] read_msg(input bit radio, input logic [PORT_W-1:0] port,
                                             input bit good);
        logic [BYTE_W-1:0] b1;
        b1    = (radio ? MSG_RADIO : 8'h00) | {2'b00, port, 4'($urandom)};
        b1[0] = b1[0] ^ (^b1) ^ good;
        return {b1, 8'($urandom)};
    endfunction

    task automatic send_item(input logic kind, input logic [LEVEL_W-1:0] lv,
                             input logic [BYTE_W-1:0] b1, input logic [BYTE_W-1:0] b2);
        in_valid     <= 1'b1;
        func         <= kind;
        radio_levels <= lv;
        msg_first    <= b1;
        msg_second   <= b2;
        do
            @(posedge clk);
        while (!in_ready);
        if (src_gaps && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                             input logic [CFG_W-1:0] slot, input logic [CFG_W-1:0] frame,
                             input logic [DIV_W-1:0] div);
        settle();
        write_reg(REG_MIN_WIDTH, lo);
        write_reg(REG_MAX_WIDTH, hi);
        write_reg(REG_SLOT_LENGTH, slot);
        write_reg(REG_FRAME_LENGTH, frame);
        write_reg(REG_CAPTURE_DIVIDER, CFG_W'(div));
        src_gaps    = $urandom_range(0, 3) != 0;
        sink_stalls = $urandom_range(0, 3) != 0;
    endtask

    task automatic random_item(input bit throttle_ok, input bit wide);
        logic [15:0] msg;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 62)
        begin
            for (int i = 0; i < LEVEL_W; i++)
                if ($urandom_range(0, 5) == 0)
                    radio_now[i] = ~radio_now[i];
            if (!throttle_ok)
                radio_now[THROTTLE] = 1'b0;
            send_item(FUNC_TICK, radio_now, 8'($urandom), 8'($urandom));
        end
        else
        begin
            if (pick < 78)
                msg = read_msg($urandom_range(0, 1), PORT_W'($urandom_range(0, 3)),
                               $urandom_range(0, 6) != 0);
            else
                msg = write_msg(PORT_W'($urandom_range(0, 3)),
                                wide ? CMD_W'($urandom) : CMD_W'($urandom_range(0, 3)),
                                $urandom_range(0, 6) != 0);
            send_item(FUNC_MSG, 4'($urandom), msg[15:8], msg[7:0]);
        end
    endtask

    initial
    begin
        logic [15:0] msg;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        func         <= FUNC_TICK;
        radio_levels <= '0;
        msg_first    <= '0;
        msg_second   <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_MIN_WIDTH;
        cfg_data     <= '0;
        src_gaps     = 1'b0;
        sink_stalls  = 1'b0;
        radio_now    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(FUNC_TICK, 4'h0, 8'h00, 8'h00);
        for (int p = 0; p < 4; p++)
        begin
            msg = read_msg(1'b0, PORT_W'(p), 1'b1);
            send_item(FUNC_MSG, 4'h0, msg[15:8], msg[7:0]);
        end
        send_item(FUNC_MSG, 4'hF, 8'h7F, 8'hFF);
        send_item(FUNC_MSG, 4'h0, 8'h00, 8'h00);
        send_item(FUNC_MSG, 4'hF, 8'hFF, 8'hFF);
        msg = write_msg(2'd2, 11'h7FF, 1'b1);
        send_item(FUNC_MSG, 4'h5, msg[15:8], msg[7:0]);
        msg = read_msg(1'b0, 2'd2, 1'b1);
        send_item(FUNC_MSG, 4'hA, msg[15:8], msg[7:0]);
        for (int p = 0; p < 4; p++)
        begin
            msg = write_msg(PORT_W'(p), CMD_W'((p + 2) % 4), 1'b1);
            send_item(FUNC_MSG, 4'h0, msg[15:8], msg[7:0]);
        end
        send_item(FUNC_TICK, 4'h1, 8'hFF, 8'h00);
        send_item(FUNC_TICK, 4'h3, 8'h00, 8'hFF);
        send_item(FUNC_TICK, 4'h7, 8'h00, 8'h00);
        send_item(FUNC_TICK, 4'h6, 8'h00, 8'h00);
        send_item(FUNC_TICK, 4'h4, 8'h00, 8'h00);
        send_item(FUNC_TICK, 4'h0, 8'h00, 8'h00);
        send_item(FUNC_TICK, 4'h5, 8'h00, 8'h00);
        send_item(FUNC_TICK, 4'h0, 8'h00, 8'h00);
        msg = read_msg(1'b1, 2'd0, 1'b1);
        send_item(FUNC_MSG, 4'h0, msg[15:8], msg[7:0]);
        msg = read_msg(1'b1, 2'd1, 1'b1);
        send_item(FUNC_MSG, 4'h0, msg[15:8], msg[7:0]);

        configure(16'd0, 16'hFFFF, 16'd6, 16'd30, 7'd1);
        repeat (90) random_item(1'b0, 1'b0);
        configure(16'd3, 16'd7, 16'd4, 16'd20, 7'd0);
        repeat (90) random_item(1'b0, 1'b0);
        configure(16'd1, 16'd12, 16'd5, 16'd25, 7'd64);
        repeat (90) random_item(1'b0, 1'b0);
        configure(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 7'd127);
        repeat (50) random_item(1'b0, 1'b1);
        configure(16'd2, 16'hFFFF, 16'd0, 16'hFFFF, 7'd1);
        repeat (70) random_item(1'b0, 1'b1);
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        repeat (60) random_item(1'b1, 1'b1);
        settle();

        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> rc_pulse_capture_and_servo_sequencer.f
rtl/core/rcps_pkg.sv
rtl/core/rc_pulse_capture_and_servo_sequencer.sv
dv/rc_pulse_capture_and_servo_sequencer_tb.sv
